[rtl/pmgn_pkg.sv]
// ----------------------------------------------------------------------------
// pmgn_pkg
// Shared types, constants and helper functions for the noise generator core.
// ----------------------------------------------------------------------------
package pmgn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_FRAC  = 24;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SQRT_W    = 57;
  localparam int SQRT_LAST = (SQRT_W - 1) / 2;

  localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
  localparam logic [14:0] LCG_MULT    = 15'd16807;
  localparam logic [30:0] RESET_STATE = 31'd16807;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // mode register codes; bit 1 set selects the gaussian path
  localparam logic [1:0] MODE_UNIT  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_GAUSS = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_SEED       = 3'd1,
    CFG_RANGE_LOW  = 3'd2,
    CFG_RANGE_HIGH = 3'd3,
    CFG_MEAN       = 3'd4,
    CFG_VARIANCE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LCG_MUL,
    S_LCG_RED,
    S_UNI,
    S_UNI_MUL,
    S_UNI_RED,
    S_SIN_X,
    S_SIN_X2M,
    S_SIN_X2,
    S_SIN_MUL,
    S_SIN_HORN,
    S_SIN_FMUL,
    S_SIN_END,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_ACC,
    S_LOG_DIFF,
    S_LN_MUL,
    S_LN_RED,
    S_VAR_MUL,
    S_VAR_RED,
    S_SQRT,
    S_ROOT_MUL,
    S_ROOT_RED,
    S_DONE
  } state_t;

  // sin(pi/2 * x) odd Taylor coefficients, Q30
  function automatic logic [30:0] sin_coef(input logic [2:0] k);
    logic [30:0] c;
    case (k)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598668;
      3'd2:    c = 31'd85569304;
      3'd3:    c = 31'd5026995;
      3'd4:    c = 31'd172272;
      default: c = '0;
    endcase
    return c;
  endfunction

  // log2 in Q5.24, used for elaboration-time constants only
  function automatic logic [28:0] log2_q24(input logic [30:0] v);
    logic [63:0] m;
    logic [4:0]  e;
    logic [23:0] frac;
    e    = '0;
    frac = '0;
    for (int j = 0; j < 31; j++) begin
      if (v[j]) e = 5'(j);
    end
    m = 64'(v) << (30 - e);
    for (int j = 1; j <= LOG_FRAC; j++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[LOG_FRAC - j] = 1'b1;
      end
    end
    return {e, frac};
  endfunction

  localparam logic [28:0] LOG2_MOD = log2_q24(LCG_MOD);

  function automatic logic [31:0] sat32(input logic signed [35:0] x);
    logic [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/park_miller_gaussian_noise_generator_core.sv]
// ----------------------------------------------------------------------------
// park_miller_gaussian_noise_generator_core
// Minimal standard Lehmer generator with uniform, ranged and Box-Muller output.
// ----------------------------------------------------------------------------
// Path, accept to out_valid: unit mode is a generator step and a scale, ranged
//   adds a shared multiply plus reduce, gaussian takes two generator steps, sine,
//   24-step log and 29-step root on the shared 33x32 multiplier; restart adds a step.
// Flow: in_ready is high in idle only, so the core takes no new item while one
//   is in flight, and an unread result holds the next one in done.
// Reset (rst, synchronous, active high): config and control registers take defaults, state 16807.
module park_miller_gaussian_noise_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample,
  output logic [30:0] state_value
);

  localparam int F = pmgn_pkg::FRAC_BITS;
  localparam int WSHIFT = pmgn_pkg::LOG_FRAC - pmgn_pkg::FRAC_BITS;

  // configuration registers
  logic [1:0]         mode;
  logic [30:0]        seed;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic signed [31:0] mean;
  logic [31:0]        variance;

  // sequencer and datapath registers
  pmgn_pkg::state_t state, state_next;
  logic [30:0] st;        // generator state between items
  logic [30:0] cur;       // latest generator value
  logic [30:0] prev;      // value before it (s1 in gaussian mode)
  logic [1:0]  cnt;       // generator steps left
  logic [2:0]  k;         // Horner / normalize step
  logic [4:0]  i;         // log bit / root iteration
  logic [pmgn_pkg::PROD_W-1:0] prod;
  logic [F:0]  u;
  logic [30:0] x;
  logic [30:0] x2;
  logic [30:0] p;
  logic [1:0]  q;
  logic [30:0] snmag;
  logic        sn_neg;
  logic [30:0] m;
  logic [4:0]  sh;
  logic [23:0] frac;
  logic [31:0] t;
  logic [pmgn_pkg::SQRT_W-1:0] v;
  logic [pmgn_pkg::SQRT_W-1:0] res;
  logic [pmgn_pkg::SQRT_W-1:0] sbit;
  logic [31:0] smp;
  logic [31:0] sample_r;
  logic [30:0] state_r;
  logic        out_v;

  // shared multiplier operands
  logic [pmgn_pkg::MUL_A_W-1:0] mul_a;
  logic [pmgn_pkg::MUL_B_W-1:0] mul_b;

  // combinational helpers
  logic [30:0] seed_fix;
  logic [31:0] lcg_sum;
  logic [30:0] lcg_red;
  logic [F-1:0] u_a;
  logic [31:0] u_ab;
  logic [31:0] ph;
  logic signed [32:0] diff;
  logic        diff_neg;
  logic [32:0] diff_mag;
  logic [30:0] norm_m;
  logic [4:0]  norm_sh;
  logic [31:0] sq;
  logic [28:0] ls;
  logic [28:0] dlog;
  logic [pmgn_pkg::SQRT_W-1:0] trial;
  logic [pmgn_pkg::PROD_W-1:0] up_uni;
  logic [pmgn_pkg::PROD_W-1:0] up_root;
  logic signed [35:0] fs_uni;
  logic signed [35:0] fs_root;
  logic [31:0] sin_p;

  // zero seed (or one congruent to zero) reloads as 1
  assign seed_fix = (seed == '0 || seed == pmgn_pkg::LCG_MOD) ? 31'd1 : seed;

  // s*16807 mod (2^31-1): fold the bits at 31 and above back in, one subtract
  assign lcg_sum = {1'b0, prod[30:0]} + 32'(prod[45:31]);
  assign lcg_red = (lcg_sum >= {1'b0, pmgn_pkg::LCG_MOD}) ?
                   31'(lcg_sum - {1'b0, pmgn_pkg::LCG_MOD}) : lcg_sum[30:0];

  // u = floor(s * 2^F / M) using 2^31 == 1 mod M
  assign u_a  = cur[30:31-F];
  assign u_ab = 32'(u_a) + {1'b0, cur[30-F:0], {F{1'b0}}};

  // phase = floor(s1 * 2^32 / M) = 2*s1 + (2*s1 >= M)
  assign ph = {prev, 1'b0} + 32'({prev, 1'b0} >= {1'b0, pmgn_pkg::LCG_MOD});

  assign diff     = 33'(range_high) - 33'(range_low);
  assign diff_neg = diff[32];
  assign diff_mag = diff_neg ? 33'(-diff) : 33'(diff);

  // leading-zero search, halving the shift each step
  always_comb begin
    norm_m  = m;
    norm_sh = sh;
    case (k)
      3'd0: if (m[30:15] == '0) begin
        norm_m  = {m[14:0], 16'b0};
        norm_sh = sh + 5'd16;
      end
      3'd1: if (m[30:23] == '0) begin
        norm_m  = {m[22:0], 8'b0};
        norm_sh = sh + 5'd8;
      end
      3'd2: if (m[30:27] == '0) begin
        norm_m  = {m[26:0], 4'b0};
        norm_sh = sh + 5'd4;
      end
      3'd3: if (m[30:29] == '0) begin
        norm_m  = {m[28:0], 2'b0};
        norm_sh = sh + 5'd2;
      end
      default: if (!m[30]) begin
        norm_m  = {m[29:0], 1'b0};
        norm_sh = sh + 5'd1;
      end
    endcase
  end

  assign sq    = prod[61:30];
  assign ls    = {5'd30 - sh, frac};
  assign dlog  = (pmgn_pkg::LOG2_MOD > ls) ? pmgn_pkg::LOG2_MOD - ls : '0;
  assign trial = res + sbit;
  assign sin_p = prod[61:30];

  // floor of signed product over 2^F and over 2^30
  assign up_uni  = prod + pmgn_pkg::PROD_W'((1 << F) - 1);
  assign up_root = prod + pmgn_pkg::PROD_W'(32'h3FFF_FFFF);
  assign fs_uni  = diff_neg ? -$signed(36'(up_uni >> F)) : $signed(36'(prod >> F));
  assign fs_root = sn_neg ? -$signed(36'(up_root >> 30)) : $signed(36'(prod >> 30));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pmgn_pkg::S_IDLE:     if (in_valid) state_next = pmgn_pkg::S_LCG_MUL;
      pmgn_pkg::S_LCG_MUL:  state_next = pmgn_pkg::S_LCG_RED;
      pmgn_pkg::S_LCG_RED: begin
        if (cnt != 2'd1)  state_next = pmgn_pkg::S_LCG_MUL;
        else if (mode[1]) state_next = pmgn_pkg::S_SIN_X;
        else              state_next = pmgn_pkg::S_UNI;
      end
      pmgn_pkg::S_UNI: begin
        state_next = (mode == pmgn_pkg::MODE_UNIT) ? pmgn_pkg::S_DONE : pmgn_pkg::S_UNI_MUL;
      end
      pmgn_pkg::S_UNI_MUL:  state_next = pmgn_pkg::S_UNI_RED;
      pmgn_pkg::S_UNI_RED:  state_next = pmgn_pkg::S_DONE;
      pmgn_pkg::S_SIN_X:    state_next = pmgn_pkg::S_SIN_X2M;
      pmgn_pkg::S_SIN_X2M:  state_next = pmgn_pkg::S_SIN_X2;
      pmgn_pkg::S_SIN_X2:   state_next = pmgn_pkg::S_SIN_MUL;
      pmgn_pkg::S_SIN_MUL:  state_next = pmgn_pkg::S_SIN_HORN;
      pmgn_pkg::S_SIN_HORN: begin
        state_next = (k == 3'd0) ? pmgn_pkg::S_SIN_FMUL : pmgn_pkg::S_SIN_MUL;
      end
      pmgn_pkg::S_SIN_FMUL: state_next = pmgn_pkg::S_SIN_END;
      pmgn_pkg::S_SIN_END:  state_next = pmgn_pkg::S_LOG_NORM;
      pmgn_pkg::S_LOG_NORM: if (k == 3'd4) state_next = pmgn_pkg::S_LOG_SQ;
      pmgn_pkg::S_LOG_SQ:   state_next = pmgn_pkg::S_LOG_ACC;
      pmgn_pkg::S_LOG_ACC: begin
        state_next = (i == '0) ? pmgn_pkg::S_LOG_DIFF : pmgn_pkg::S_LOG_SQ;
      end
      pmgn_pkg::S_LOG_DIFF: state_next = pmgn_pkg::S_LN_MUL;
      pmgn_pkg::S_LN_MUL:   state_next = pmgn_pkg::S_LN_RED;
      pmgn_pkg::S_LN_RED:   state_next = pmgn_pkg::S_VAR_MUL;
      pmgn_pkg::S_VAR_MUL:  state_next = pmgn_pkg::S_VAR_RED;
      pmgn_pkg::S_VAR_RED:  state_next = pmgn_pkg::S_SQRT;
      pmgn_pkg::S_SQRT:     if (i == '0) state_next = pmgn_pkg::S_ROOT_MUL;
      pmgn_pkg::S_ROOT_MUL: state_next = pmgn_pkg::S_ROOT_RED;
      pmgn_pkg::S_ROOT_RED: state_next = pmgn_pkg::S_DONE;
      pmgn_pkg::S_DONE:     if (!out_v || out_ready) state_next = pmgn_pkg::S_IDLE;
      default:              state_next = pmgn_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      pmgn_pkg::S_IDLE:     in_ready = 1'b1;
      pmgn_pkg::S_LCG_MUL: begin
        mul_a = 33'(cur);
        mul_b = 32'(pmgn_pkg::LCG_MULT);
      end
      pmgn_pkg::S_UNI_MUL: begin
        mul_a = diff_mag;
        mul_b = 32'(u);
      end
      pmgn_pkg::S_SIN_X2M: begin
        mul_a = 33'(x);
        mul_b = 32'(x);
      end
      pmgn_pkg::S_SIN_MUL: begin
        mul_a = 33'(p);
        mul_b = 32'(x2);
      end
      pmgn_pkg::S_SIN_FMUL: begin
        mul_a = 33'(p);
        mul_b = 32'(x);
      end
      pmgn_pkg::S_LOG_SQ: begin
        mul_a = 33'(m);
        mul_b = 32'(m);
      end
      pmgn_pkg::S_LN_MUL: begin
        mul_a = 33'(t);
        mul_b = 32'(pmgn_pkg::LN2_Q30);
      end
      pmgn_pkg::S_VAR_MUL: begin
        mul_a = 33'(t);
        mul_b = variance;
      end
      pmgn_pkg::S_ROOT_MUL: begin
        mul_a = 33'(snmag);
        mul_b = res[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pmgn_pkg::MODE_UNIT;
      seed       <= 31'd1;
      range_low  <= '0;
      range_high <= 32'sd65536;
      mean       <= '0;
      variance   <= 32'd65536;
    end else if (cfg_we) begin
      unique case (pmgn_pkg::cfg_idx_t'(cfg_index))
        pmgn_pkg::CFG_MODE:       mode       <= cfg_wdata[1:0];
        pmgn_pkg::CFG_SEED:       seed       <= cfg_wdata[30:0];
        pmgn_pkg::CFG_RANGE_LOW:  range_low  <= cfg_wdata;
        pmgn_pkg::CFG_RANGE_HIGH: range_high <= cfg_wdata;
        pmgn_pkg::CFG_MEAN:       mean       <= cfg_wdata;
        pmgn_pkg::CFG_VARIANCE:   variance   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmgn_pkg::S_IDLE;
      st    <= pmgn_pkg::RESET_STATE;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pmgn_pkg::S_DONE && (!out_v || out_ready)) begin
        out_v <= 1'b1;
        st    <= cur;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // datapath; the shared product register loads every cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      pmgn_pkg::S_IDLE: begin
        cur <= restart ? seed_fix : st;
        cnt <= 2'(restart) + (mode[1] ? 2'd2 : 2'd1);
      end
      pmgn_pkg::S_LCG_RED: begin
        prev <= cur;
        cur  <= lcg_red;
        cnt  <= cnt - 2'd1;
      end
      pmgn_pkg::S_UNI: begin
        u   <= (F+1)'(u_a) + (F+1)'(u_ab >= {1'b0, pmgn_pkg::LCG_MOD});
        smp <= 32'(u_a) + 32'(u_ab >= {1'b0, pmgn_pkg::LCG_MOD});
      end
      pmgn_pkg::S_UNI_RED: smp <= pmgn_pkg::sat32(36'(range_low) + fs_uni);
      pmgn_pkg::S_SIN_X: begin
        q <= ph[31:30];
        x <= ph[30] ? pmgn_pkg::ONE_Q30 - 31'(ph[29:0]) : 31'(ph[29:0]);
      end
      pmgn_pkg::S_SIN_X2: begin
        x2 <= prod[60:30];
        p  <= pmgn_pkg::sin_coef(3'd4);
        k  <= 3'd3;
      end
      pmgn_pkg::S_SIN_HORN: begin
        p <= 31'(32'(pmgn_pkg::sin_coef(k)) - sin_p);
        k <= k - 3'd1;
      end
      pmgn_pkg::S_SIN_END: begin
        snmag  <= (sin_p > 32'(pmgn_pkg::ONE_Q30)) ? pmgn_pkg::ONE_Q30 : sin_p[30:0];
        sn_neg <= q[1];
        m      <= cur;
        sh     <= '0;
        k      <= '0;
      end
      pmgn_pkg::S_LOG_NORM: begin
        m    <= norm_m;
        sh   <= norm_sh;
        k    <= k + 3'd1;
        i    <= 5'(pmgn_pkg::LOG_FRAC - 1);
        frac <= '0;
      end
      pmgn_pkg::S_LOG_ACC: begin
        m       <= sq[31] ? sq[31:1] : sq[30:0];
        frac[i] <= sq[31];
        i       <= i - 5'd1;
      end
      pmgn_pkg::S_LOG_DIFF: t <= 32'({dlog, 1'b0});
      pmgn_pkg::S_LN_RED:   t <= prod[61:30];
      pmgn_pkg::S_VAR_RED: begin
        v    <= pmgn_pkg::SQRT_W'(prod >> WSHIFT);
        res  <= '0;
        sbit <= pmgn_pkg::SQRT_W'(1) << (2 * pmgn_pkg::SQRT_LAST);
        i    <= 5'(pmgn_pkg::SQRT_LAST);
      end
      pmgn_pkg::S_SQRT: begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        i    <= i - 5'd1;
      end
      pmgn_pkg::S_ROOT_RED: smp <= pmgn_pkg::sat32(36'(mean) + fs_root);
      pmgn_pkg::S_DONE: begin
        if (!out_v || out_ready) begin
          sample_r <= smp;
          state_r  <= cur;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_v;
  assign sample      = sample_r;
  assign state_value = state_r;

`ifndef SYNTHESIS
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    state == pmgn_pkg::S_LCG_MUL |-> cnt != 2'd0)
    else $error("generator step with no steps left");
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (state_r != '0 && state_r != pmgn_pkg::LCG_MOD))
    else $error("generator state left its range");
  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    state == pmgn_pkg::S_SQRT |-> $onehot(sbit))
    else $error("root trial bit lost");
  a_sine_cap: assert property (@(posedge clk) disable iff (rst)
    state == pmgn_pkg::S_LOG_NORM |-> snmag <= pmgn_pkg::ONE_Q30)
    else $error("sine magnitude above one");
`endif

endmodule

[sim/park_miller_gaussian_noise_generator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_miller_gaussian_noise_generator_core_test
// Drives restart and continued items through the noise core under each output mode and
// register setting, predicts every sample and state in fixed point, and
// compares each result as it leaves the core.
// ----------------------------------------------------------------------------
module park_miller_gaussian_noise_generator_core_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sample;
  logic [30:0] state_value;

  park_miller_gaussian_noise_generator_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .restart(restart), .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .state_value(state_value)
  );

  always #10 clk = ~clk;

  // Predictor copy of the configuration and the generator state
  logic [1:0]  cur_mode;
  logic [30:0] cur_seed;
  logic [31:0] cur_low, cur_high, cur_mean, cur_var;
  logic [30:0] gen_state;

  typedef struct packed {
    logic [31:0] smp;
    logic [30:0] st;
  } noise_t;
  noise_t expected_noise[$];

  int errors = 0;
  int n_items = 0, n_results = 0, n_gauss = 0;
  bit quiet = 0;  // no idling on either side while set

  function automatic logic [63:0] lehmer(input logic [63:0] s);
    return (s * 64'd16807) % 64'd2147483647;
  endfunction

  function automatic logic [63:0] seeded_state(input logic [30:0] sd);
    logic [63:0] s;
    s = 64'(sd) % 64'd2147483647;
    if (s == 0) s = 1;
    return lehmer(s);
  endfunction

  function automatic longint floor_div(input longint x, input int n);
    longint q;
    if (x >= 0) q = x >>> n;
    else q = -longint'((64'(-x) + ((64'd1 << n) - 1)) >> n);
    return q;
  endfunction

  function automatic logic [31:0] clip32(input longint x);
    logic [31:0] r;
    if (x > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (x < -64'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // log2 in Q5.24: exponent by normalization, fraction by repeated squaring
  function automatic logic [63:0] log2_fixed(input logic [63:0] v);
    logic [63:0] m, frac;
    int e;
    e = 0;
    frac = 0;
    if (v == 0) v = 1;
    while (e < 30 && (v >> (e + 1)) != 0) e++;
    m = v << (30 - e);
    for (int i = 1; i <= 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << (24 - i);
      end
    end
    return (64'(e) << 24) | frac;
  endfunction

  // sine of a Q0.32 turn, Q30 signed
  function automatic longint sine_turn(input logic [63:0] ph);
    logic [63:0] coef[5];
    logic [63:0] q, r, x, x2, p;
    coef[0] = 1686629713; coef[1] = 693598668; coef[2] = 85569304;
    coef[3] = 5026995; coef[4] = 172272;
    q = (ph >> 30) & 3;
    r = ph & ((64'd1 << 30) - 1);
    x = q[0] ? (64'd1 << 30) - r : r;
    x2 = (x * x) >> 30;
    p = coef[4];
    for (int k = 3; k >= 0; k--) p = coef[k] - ((p * x2) >> 30);
    p = (p * x) >> 30;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    return q[1] ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Advance the predictor by one draw and queue the result
  task automatic predict_draw(input logic rs);
    logic [63:0] s, s1, s2, ph, lm, ls, d, t, w, root;
    longint u, sn, lo, diff;
    noise_t nz;
    s = rs ? seeded_state(cur_seed) : 64'(gen_state);
    s = s % 64'd2147483647;
    if (cur_mode[1]) begin
      s1 = lehmer(s);
      s2 = lehmer(s1);
      ph = (s1 << 32) / 64'd2147483647;
      sn = sine_turn(ph);
      lm = log2_fixed(64'd2147483647);
      ls = log2_fixed(s2);
      d = lm > ls ? lm - ls : 0;
      t = (2 * d * 64'd744261118) >> 30;
      w = (t * 64'(cur_var)) >> (24 - pmgn_pkg::FRAC_BITS);
      root = int_sqrt(w);
      nz.smp = clip32(longint'(signed'(cur_mean)) + floor_div(sn * longint'(root), 30));
      s = s2;
      n_gauss++;
    end else begin
      s1 = lehmer(s);
      u = longint'((s1 << pmgn_pkg::FRAC_BITS) / 64'd2147483647);
      if (cur_mode == pmgn_pkg::MODE_UNIT) begin
        nz.smp = clip32(u);
      end else begin
        lo = longint'(signed'(cur_low));
        diff = longint'(signed'(cur_high)) - lo;
        nz.smp = clip32(lo + floor_div(diff * u, pmgn_pkg::FRAC_BITS));
      end
      s = s1;
    end
    gen_state = s[30:0];
    nz.st = s[30:0];
    expected_noise.push_back(nz);
  endtask

  // Register write; waits until no item is left in the core
  task automatic write_reg(input pmgn_pkg::cfg_idx_t idx, input logic [31:0] val);
    while (expected_noise.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pmgn_pkg::CFG_MODE:       cur_mode = val[1:0];
      pmgn_pkg::CFG_SEED:       cur_seed = val[30:0];
      pmgn_pkg::CFG_RANGE_LOW:  cur_low = val;
      pmgn_pkg::CFG_RANGE_HIGH: cur_high = val;
      pmgn_pkg::CFG_MEAN:       cur_mean = val;
      pmgn_pkg::CFG_VARIANCE:   cur_var = val;
      default: ;
    endcase
  endtask

  // Send one request item; valid held until accepted. The core stays busy after
  // an accept, so dropping valid between items costs nothing.
  task automatic send_draw(input logic rs);
    while (!quiet && $urandom_range(99) < 10) @(posedge clk);
    in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    predict_draw(rs);
    n_items++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued result is back, then let the core settle
  task automatic drain;
    int guard;
    guard = 0;
    while (expected_noise.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // Result side: random stall, compare on each accepted item
  always @(posedge clk) begin
    noise_t nz;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_noise.size() == 0) begin
          $display("%0t unexpected result: sample %h state %0d", $time, sample,
                   state_value);
          errors++;
        end else begin
          nz = expected_noise.pop_front();
          n_results++;
          if (sample !== nz.smp) begin
            $display("%0t sample mismatch: expected %h actual %h", $time, nz.smp, sample);
            errors++;
          end
          if (state_value !== nz.st) begin
            $display("%0t state mismatch: expected %0d actual %0d", $time, nz.st,
                     state_value);
            errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Field extremes, restart both ways and the zero-seed cases
  task automatic test_unit_mode;
    write_reg(pmgn_pkg::CFG_MODE, 32'(pmgn_pkg::MODE_UNIT));
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    write_reg(pmgn_pkg::CFG_SEED, 32'd0);  // zero seed becomes one
    send_draw(1'b1);
    write_reg(pmgn_pkg::CFG_SEED, 32'h7FFF_FFFF);  // congruent to zero
    send_draw(1'b1);
    write_reg(pmgn_pkg::CFG_SEED, 32'h7FFF_FFFE);
    send_draw(1'b1);
    send_draw(1'b0);
    drain();
  endtask

  // Ranged mode: wide, reversed and saturating bounds
  task automatic test_range_mode;
    write_reg(pmgn_pkg::CFG_MODE, 32'(pmgn_pkg::MODE_RANGE));
    write_reg(pmgn_pkg::CFG_RANGE_LOW, 32'hFFFF_0000);
    write_reg(pmgn_pkg::CFG_RANGE_HIGH, 32'h0001_0000);
    send_draw(1'b0);
    write_reg(pmgn_pkg::CFG_RANGE_LOW, 32'h7FFF_FFFF);  // reversed bounds
    write_reg(pmgn_pkg::CFG_RANGE_HIGH, 32'h8000_0000);
    send_draw(1'b0);
    send_draw(1'b1);
    write_reg(pmgn_pkg::CFG_RANGE_LOW, 32'h8000_0000);
    write_reg(pmgn_pkg::CFG_RANGE_HIGH, 32'h7FFF_FFFF);
    send_draw(1'b0);
    drain();
  endtask

  // Gaussian and spare mode with extreme mean and variance
  task automatic test_gauss_mode;
    write_reg(pmgn_pkg::CFG_MODE, 32'(pmgn_pkg::MODE_GAUSS));
    send_draw(1'b0);
    write_reg(pmgn_pkg::CFG_MEAN, 32'h7FFF_FFFF);  // saturates high
    write_reg(pmgn_pkg::CFG_VARIANCE, 32'hFFFF_FFFF);
    send_draw(1'b0);
    write_reg(pmgn_pkg::CFG_MEAN, 32'h8000_0000);
    send_draw(1'b1);
    write_reg(pmgn_pkg::CFG_VARIANCE, 32'd0);
    send_draw(1'b0);
    write_reg(pmgn_pkg::CFG_MODE, 32'(pmgn_pkg::MODE_SPARE));  // acts as gaussian
    write_reg(pmgn_pkg::CFG_MEAN, 32'd0);
    write_reg(pmgn_pkg::CFG_VARIANCE, 32'h0010_0000);
    send_draw(1'b0);
    drain();
  endtask

  // Random phases: new registers between phases, mostly continued sequences
  task automatic test_random_phases;
    logic [31:0] m;
    int len;
    for (int ph = 0; ph < 40; ph++) begin
      quiet = (ph >= 10 && ph < 14);
      m = (ph % 4 == 3) ? 32'(pmgn_pkg::MODE_GAUSS) + 32'($urandom_range(1))
                        : 32'($urandom_range(1));
      write_reg(pmgn_pkg::CFG_MODE, m);
      write_reg(pmgn_pkg::CFG_SEED, $urandom());
      write_reg(pmgn_pkg::CFG_RANGE_LOW, $urandom_range(3) == 0 ? $urandom()
                : {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000);
      write_reg(pmgn_pkg::CFG_RANGE_HIGH, $urandom_range(3) == 0 ? $urandom()
                : 32'($urandom_range(8000000)));
      write_reg(pmgn_pkg::CFG_MEAN, $urandom());
      write_reg(pmgn_pkg::CFG_VARIANCE, $urandom_range(3) == 0 ? $urandom()
                : 32'($urandom_range(1 << 22)));
      len = (m[1]) ? 10 : 30;
      for (int i = 0; i < len; i++) send_draw($urandom_range(15) == 0);
      drain();
    end
    quiet = 0;
  endtask

  initial begin
    cur_mode = 0; cur_seed = 1; cur_low = 0; cur_high = 32'd65536;
    cur_mean = 0; cur_var = 32'd65536; gen_state = pmgn_pkg::RESET_STATE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unit_mode();
    test_range_mode();
    test_gauss_mode();
    test_random_phases();
    drain();
    $display("Run covered %0d items, %0d results, %0d gaussian draws.",
             n_items, n_results, n_gauss);
    if (errors == 0 && expected_noise.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_noise.size() != 0)
        $display("%0t %0d results never arrived", $time, expected_noise.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
